// File: src/preemptive_priority_scheduler_macros.svh
// Assertion macros used by the checker file.
// Both forms sample on clk and are disabled while rst is high.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Types, codes and constants of the preemptive priority scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int TW        = 16;   // time, arrival and burst width

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_ZERO_BURST = 2'd2;
  localparam logic [1:0] STATUS_TIME_SAT  = 2'd3;

  localparam logic [8:0]    NONE_MARK = 9'h100;
  localparam logic [TW-1:0] TIME_MAX  = '1;

  typedef struct packed {
    logic [1:0]    mode;
    logic [7:0]    task_id;
    logic [TW-1:0] arrival;
    logic [TW-1:0] burst;
    logic [7:0]    priority_req;
  } req_t;

  typedef struct packed {
    logic [1:0]    status;
    logic          idle;
    logic [7:0]    running_id;
    logic          new_segment;
    logic [TW-1:0] tick_start;
    logic          finished;
    logic [TW-1:0] completion_time;
    logic [TW-1:0] turnaround;
    logic [TW-1:0] waiting;
    logic          all_done;
  } rsp_t;

  typedef struct packed {
    logic [7:0]    id;
    logic [TW-1:0] arrival;
    logic [TW-1:0] burst;
    logic [7:0]    prio;
    logic [TW-1:0] remaining;
  } entry_t;

  typedef struct packed {
    logic all;   // write the whole entry
    logic rem;   // write the remaining field only
  } tbl_wr_t;

endpackage

`default_nettype wire

// File: src/pps_table.sv
// ----------------------------------------------------------------------------
// pps_table
// Task slot memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_table #(
  parameter int SLOTS = pps_pkg::SLOTS_DEF,
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic             clk,
  input  wire pps_pkg::tbl_wr_t wr,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire pps_pkg::entry_t  wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output pps_pkg::entry_t       rd_data
);

  pps_pkg::entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr.all) begin
      mem[wr_addr] <= wr_data;
    end else if (wr.rem) begin
      mem[wr_addr].remaining <= wr_data.remaining;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: src/pps_serial_sub.sv
// ----------------------------------------------------------------------------
// pps_serial_sub
// Bit-serial chained subtractor: tat = a - b, wt = max(tat - c, 0).
// ----------------------------------------------------------------------------
`default_nettype none

module pps_serial_sub (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [pps_pkg::TW-1:0] a,
  input  wire logic [pps_pkg::TW-1:0] b,
  input  wire logic [pps_pkg::TW-1:0] c,
  output logic                        done,
  output logic [pps_pkg::TW-1:0]      tat,
  output logic [pps_pkg::TW-1:0]      wt
);

  localparam int TW   = pps_pkg::TW;
  localparam int CNTW = $clog2(TW);
  localparam logic [CNTW-1:0] CNT_LAST = CNTW'(TW - 1);

  logic [TW-1:0]   a_sr, b_sr, c_sr, tat_sr, wt_sr;
  logic            br1, br2, neg, busy;
  logic [CNTW-1:0] cnt;
  logic            d1, d2, br1_next, br2_next;

  // LSB first: the first difference feeds the second in the same bit slot
  always_comb begin
    d1       = a_sr[0] ^ b_sr[0] ^ br1;
    br1_next = (~a_sr[0] & b_sr[0]) | (~(a_sr[0] ^ b_sr[0]) & br1);
    d2       = d1 ^ c_sr[0] ^ br2;
    br2_next = (~d1 & c_sr[0]) | (~(d1 ^ c_sr[0]) & br2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        a_sr <= a;
        b_sr <= b;
        c_sr <= c;
        br1  <= 1'b0;
        br2  <= 1'b0;
      end else if (busy) begin
        a_sr   <= a_sr >> 1;
        b_sr   <= b_sr >> 1;
        c_sr   <= c_sr >> 1;
        tat_sr <= {d1, tat_sr[TW-1:1]};
        wt_sr  <= {d2, wt_sr[TW-1:1]};
        br1    <= br1_next;
        br2    <= br2_next;
        cnt    <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
          neg  <= br2_next;
        end
      end
    end
  end

  assign tat = tat_sr;
  assign wt  = neg ? '0 : wt_sr;

endmodule

`default_nettype wire

// File: src/preemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Tick-driven preemptive priority scheduler over a table of task slots.
// ----------------------------------------------------------------------------
// One transaction on req is one step: load a task, advance one tick, or clear.
// Loads, clears and the unused mode go from the idle state straight to the
// done state. A tick scans the slot memory one slot per cycle through its
// single registered read port; when the running task completes, the
// turnaround and waiting times then go through a bit-serial subtractor.
// The next transaction is taken while a result still waits on rsp.
`default_nettype none

module preemptive_priority_scheduler #(
  parameter int SLOTS = pps_pkg::SLOTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire pps_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output pps_pkg::rsp_t      rsp
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int TW = pps_pkg::TW;
  localparam logic [CW-1:0] COUNT_FULL = CW'(SLOTS);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_SUB, ST_DONE} state_t;

  state_t            state;
  logic [CW-1:0]     task_count, finished_count, scan_idx;
  logic [TW-1:0]     cur_time, tend;
  logic [8:0]        last_running;
  logic              eval_v, found;
  logic [7:0]        best_pri;
  logic [AW-1:0]     win_idx;
  pps_pkg::entry_t   win;
  pps_pkg::rsp_t     res, res_next;

  pps_pkg::tbl_wr_t  wr;
  logic [AW-1:0]     wr_addr;
  pps_pkg::entry_t   wr_data;
  pps_pkg::entry_t   rd_data;

  logic              accept, load_ok, issue, cand, scan_end, sub_start, sub_done;
  logic              rsp_load;
  logic [TW-1:0]     rem_dec, sub_tat, sub_wt;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign load_ok   = (req.mode == pps_pkg::MODE_LOAD) && (task_count != COUNT_FULL) &&
                     (req.burst != '0);
  assign issue     = (state == ST_SCAN) && (scan_idx < task_count);
  assign cand      = eval_v && (rd_data.arrival <= cur_time) && (rd_data.remaining != '0) &&
                     (!found || (rd_data.prio < best_pri));
  assign scan_end  = (state == ST_SCAN) && !issue && !eval_v;
  assign rem_dec   = win.remaining - 1'b1;
  assign sub_start = scan_end && found && (rem_dec == '0);
  assign rsp_load  = (state == ST_DONE) && (!rsp_valid || !rsp_stall);

  always_comb begin
    wr      = '0;
    wr_addr = task_count[AW-1:0];
    wr_data = '{id: req.task_id, arrival: req.arrival, burst: req.burst,
                prio: req.priority_req, remaining: req.burst};
    if (accept && load_ok) begin
      wr.all = 1'b1;
    end else if (scan_end && found) begin
      wr.rem            = 1'b1;
      wr_addr           = win_idx;
      wr_data.remaining = rem_dec;
    end
  end

  // Build the pending result field by field as the transaction advances.
  always_comb begin
    res_next = res;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          res_next            = '0;
          res_next.tick_start = cur_time;
          unique case (req.mode)
            pps_pkg::MODE_LOAD: begin
              if (task_count == COUNT_FULL) begin
                res_next.status = pps_pkg::STATUS_FULL;
              end else if (req.burst == '0) begin
                res_next.status = pps_pkg::STATUS_ZERO_BURST;
              end
            end
            pps_pkg::MODE_CLEAR: begin
              res_next.tick_start = '0;
            end
            pps_pkg::MODE_TICK: begin
              if (cur_time == pps_pkg::TIME_MAX) begin
                res_next.status = pps_pkg::STATUS_TIME_SAT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          if (!found) begin
            res_next.idle = 1'b1;
          end else begin
            res_next.running_id  = win.id;
            res_next.new_segment = (last_running != {1'b0, win.id});
            if (rem_dec == '0) begin
              res_next.finished        = 1'b1;
              res_next.completion_time = tend;
            end
          end
        end
      end
      ST_SUB: begin
        if (sub_done) begin
          res_next.turnaround = sub_tat;
          res_next.waiting    = sub_wt;
        end
      end
      ST_DONE: begin
        res_next.all_done = (finished_count == task_count);
      end
      default: begin
      end
    endcase
  end

  pps_table #(.SLOTS(SLOTS)) u_table (
    .clk     (clk),
    .wr      (wr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (scan_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  pps_serial_sub u_sub (
    .clk   (clk),
    .rst   (rst),
    .start (sub_start),
    .a     (tend),
    .b     (win.arrival),
    .c     (win.burst),
    .done  (sub_done),
    .tat   (sub_tat),
    .wt    (sub_wt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      task_count     <= '0;
      finished_count <= '0;
      cur_time       <= '0;
      last_running   <= pps_pkg::NONE_MARK;
      rsp_valid      <= 1'b0;
      eval_v         <= 1'b0;
      found          <= 1'b0;
      scan_idx       <= '0;
    end else begin
      rsp_valid <= rsp_load || (rsp_valid && rsp_stall);
      res       <= res_next;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (req.mode)
              pps_pkg::MODE_LOAD: begin
                if (load_ok) begin
                  task_count <= task_count + 1'b1;
                end
                state <= ST_DONE;
              end
              pps_pkg::MODE_CLEAR: begin
                task_count     <= '0;
                finished_count <= '0;
                cur_time       <= '0;
                last_running   <= pps_pkg::NONE_MARK;
                state          <= ST_DONE;
              end
              pps_pkg::MODE_TICK: begin
                if (cur_time == pps_pkg::TIME_MAX) begin
                  tend <= cur_time;
                end else begin
                  tend <= cur_time + 1'b1;
                end
                scan_idx <= '0;
                eval_v   <= 1'b0;
                found    <= 1'b0;
                state    <= ST_SCAN;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_SCAN: begin
          eval_v <= issue;
          if (issue) begin
            scan_idx <= scan_idx + 1'b1;
          end
          if (cand) begin
            found    <= 1'b1;
            best_pri <= rd_data.prio;
            win      <= rd_data;
            win_idx  <= AW'(scan_idx - 1'b1);
          end
          if (scan_end) begin
            cur_time <= tend;
            if (!found) begin
              last_running <= pps_pkg::NONE_MARK;
              state        <= ST_DONE;
            end else begin
              last_running <= {1'b0, win.id};
              if (rem_dec == '0) begin
                finished_count <= finished_count + 1'b1;
                state          <= ST_SUB;
              end else begin
                state <= ST_DONE;
              end
            end
          end
        end
        ST_SUB: begin
          if (sub_done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (rsp_load) begin
            rsp   <= res_next;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/pps_checker.sv
// ----------------------------------------------------------------------------
// pps_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "preemptive_priority_scheduler_macros.svh"

module pps_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_stall,
  input wire pps_pkg::req_t req,
  input wire logic          rsp_valid,
  input wire logic          rsp_stall,
  input wire pps_pkg::rsp_t rsp
);

  `PPS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
                   rsp_valid && $stable(rsp), "stalled transaction changed")
  `PPS_ASSERT_NEXT(a_one_in_flight, req_valid && !req_stall,
                   req_stall, "second transaction taken while busy")
  `PPS_ASSERT_NOW(a_idle_no_finish, rsp_valid && rsp.idle,
                  !rsp.finished && rsp.running_id == 8'd0, "idle tick reports a running task")
  `PPS_ASSERT_NOW(a_wait_bound, rsp_valid && rsp.finished,
                  rsp.waiting <= rsp.turnaround, "waiting exceeds turnaround")

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (.*);

`default_nettype wire

// File: dv/preemptive_priority_scheduler_tb.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_tb
// Self-checking bench for the tick-driven preemptive priority scheduler.
// ----------------------------------------------------------------------------
// A short scripted sequence hits reset state, a rejected load, the unused mode,
// priority ties, completion and idle ticks. Random task sets follow, with
// random gaps on both channels and one long output hold-off. Every response is
// checked field by field against an in-bench scheduler model or a scripted value.
`default_nettype none

module preemptive_priority_scheduler_tb;

  localparam int          N_SLOTS     = pps_pkg::SLOTS_DEF;
  localparam int          RAND_ITEMS  = 1300;
  localparam int          HOLD_CYCLES = 400;
  localparam int          DRAIN_WAIT  = 60;
  localparam int          LIMIT       = 3_000_000;
  localparam logic [1:0]  MODE_SPARE  = 2'd3;

  typedef struct {
    pps_pkg::req_t r;
    bit            typed;
    pps_pkg::rsp_t want;
  } step_row_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  pps_pkg::req_t req = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  pps_pkg::rsp_t rsp;

  // scheduler model state
  logic [7:0]  tbl_id   [N_SLOTS];
  logic [15:0] tbl_arr  [N_SLOTS];
  logic [15:0] tbl_len  [N_SLOTS];
  logic [7:0]  tbl_pri  [N_SLOTS];
  logic [15:0] tbl_left [N_SLOTS];
  int          loaded   = 0;
  int          done_cnt = 0;
  logic [15:0] clock_now = '0;
  logic [8:0]  prev_run  = pps_pkg::NONE_MARK;

  pps_pkg::rsp_t sched_q[$];
  step_row_t     script[$];

  int  cycles = 0;
  int  errors = 0;
  int  sent = 0;
  int  n_load = 0, n_tick = 0, n_clear = 0, n_spare = 0, n_fin = 0, n_sat = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  want_hold = 1'b0;
  bit  gaps_on = 1'b1;

  preemptive_priority_scheduler DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycles, sched_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic pps_pkg::req_t mk(logic [1:0] m, logic [7:0] id, logic [15:0] arr,
                                       logic [15:0] len, logic [7:0] pri);
    pps_pkg::req_t r;
    r.mode         = m;
    r.task_id      = id;
    r.arrival      = arr;
    r.burst        = len;
    r.priority_req = pri;
    return r;
  endfunction

  function automatic pps_pkg::rsp_t plain(logic [1:0] st, logic idl, logic [15:0] ts,
                                          logic ad);
    pps_pkg::rsp_t o;
    o            = '0;
    o.status     = st;
    o.idle       = idl;
    o.tick_start = ts;
    o.all_done   = ad;
    return o;
  endfunction

  // Advance the scheduler model by one transaction and return its response.
  function automatic pps_pkg::rsp_t sched_step(pps_pkg::req_t r);
    pps_pkg::rsp_t o;
    bit            found;
    int            win;
    logic [7:0]    best;
    logic [15:0]   tend;
    logic [15:0]   tat;
    o = '0;
    found = 1'b0;
    win = 0;
    best = '0;
    case (r.mode)
      pps_pkg::MODE_LOAD: begin
        if (loaded >= N_SLOTS) begin
          o.status = pps_pkg::STATUS_FULL;
        end else if (r.burst == '0) begin
          o.status = pps_pkg::STATUS_ZERO_BURST;
        end else begin
          tbl_id[loaded]   = r.task_id;
          tbl_arr[loaded]  = r.arrival;
          tbl_len[loaded]  = r.burst;
          tbl_pri[loaded]  = r.priority_req;
          tbl_left[loaded] = r.burst;
          loaded++;
        end
        o.tick_start = clock_now;
      end
      pps_pkg::MODE_CLEAR: begin
        loaded    = 0;
        done_cnt  = 0;
        clock_now = '0;
        prev_run  = pps_pkg::NONE_MARK;
      end
      pps_pkg::MODE_TICK: begin
        o.tick_start = clock_now;
        for (int i = 0; i < loaded; i++) begin
          if (tbl_arr[i] <= clock_now && tbl_left[i] != '0 &&
              (!found || tbl_pri[i] < best)) begin
            found = 1'b1;
            best  = tbl_pri[i];
            win   = i;
          end
        end
        if (clock_now == pps_pkg::TIME_MAX) begin
          o.status = pps_pkg::STATUS_TIME_SAT;
          tend = clock_now;
        end else begin
          tend = clock_now + 16'd1;
        end
        if (!found) begin
          o.idle   = 1'b1;
          prev_run = pps_pkg::NONE_MARK;
        end else begin
          o.running_id  = tbl_id[win];
          o.new_segment = (prev_run != {1'b0, tbl_id[win]});
          prev_run      = {1'b0, tbl_id[win]};
          tbl_left[win] = tbl_left[win] - 16'd1;
          if (tbl_left[win] == '0) begin
            tat               = tend - tbl_arr[win];
            o.finished        = 1'b1;
            o.completion_time = tend;
            o.turnaround      = tat;
            o.waiting         = (tat >= tbl_len[win]) ? tat - tbl_len[win] : '0;
            done_cnt++;
          end
        end
        clock_now = tend;
      end
      default: o.tick_start = clock_now;
    endcase
    o.all_done = (done_cnt == loaded);
    return o;
  endfunction

  task automatic report(input string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  task automatic cmp(input string field, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) report($sformatf("%s got %0d want %0d", field, got, want));
  endtask

  // Check each response transaction against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (sched_q.size() == 0) begin
        report("response with nothing outstanding");
      end else begin
        cmp("status", 16'(rsp.status), 16'(sched_q[0].status));
        cmp("idle", 16'(rsp.idle), 16'(sched_q[0].idle));
        cmp("running_id", 16'(rsp.running_id), 16'(sched_q[0].running_id));
        cmp("new_segment", 16'(rsp.new_segment), 16'(sched_q[0].new_segment));
        cmp("tick_start", rsp.tick_start, sched_q[0].tick_start);
        cmp("finished", 16'(rsp.finished), 16'(sched_q[0].finished));
        cmp("completion_time", rsp.completion_time, sched_q[0].completion_time);
        cmp("turnaround", rsp.turnaround, sched_q[0].turnaround);
        cmp("waiting", rsp.waiting, sched_q[0].waiting);
        cmp("all_done", 16'(rsp.all_done), 16'(sched_q[0].all_done));
        if (sched_q[0].finished) n_fin++;
        if (sched_q[0].status == pps_pkg::STATUS_TIME_SAT) n_sat++;
        void'(sched_q.pop_front());
      end
    end
  end

  // Output side: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (want_hold) begin
      want_hold = 1'b0;
      hold_left = HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
      if (gaps_on && $urandom_range(0, 2) == 0) stall_left = pick_len();
    end
  end

  // Called and returns at a falling edge; predicts on acceptance.
  task automatic send(input pps_pkg::req_t r, input bit typed = 1'b0,
                      input pps_pkg::rsp_t want = '0);
    int            gap;
    pps_pkg::rsp_t p;
    gap = gaps_on ? pick_len() : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    p = sched_step(r);
    sched_q = {sched_q, (typed ? want : p)};
    sent++;
    case (r.mode)
      pps_pkg::MODE_LOAD:  n_load++;
      pps_pkg::MODE_TICK:  n_tick++;
      pps_pkg::MODE_CLEAR: n_clear++;
      default:             n_spare++;
    endcase
    @(negedge clk);
  endtask

  task automatic add(input pps_pkg::req_t r, input bit typed = 1'b0,
                     input pps_pkg::rsp_t want = '0);
    step_row_t s;
    s.r     = r;
    s.typed = typed;
    s.want  = want;
    script = {script, s};
  endtask

  function automatic pps_pkg::req_t rand_load();
    int          a, b;
    logic [15:0] arr, len;
    logic [7:0]  pri;
    a = $urandom_range(0, 99);
    b = $urandom_range(0, 99);
    if (a < 80) arr = 16'($urandom_range(0, 30));
    else if (a < 90) arr = 16'($urandom_range(0, 1000));
    else arr = 16'($urandom_range(0, 65535));
    if (b < 5) len = '0;
    else if (b < 85) len = 16'($urandom_range(1, 8));
    else if (b < 95) len = 16'($urandom_range(9, 40));
    else len = 16'($urandom_range(1, 65535));
    pri = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
    return mk(pps_pkg::MODE_LOAD, 8'($urandom_range(0, 255)), arr, len, pri);
  endfunction

  function automatic pps_pkg::req_t rand_any();
    return mk(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              8'($urandom_range(0, 255)));
  endfunction

  initial begin
    int base;
    int set_no;
    int nl;
    int nt;

    // empty table, unused mode, clear, zero-burst load
    add(mk(pps_pkg::MODE_TICK, 0, 0, 0, 0), 1'b1,
        plain(pps_pkg::STATUS_OK, 1'b1, 16'd0, 1'b1));
    add(mk(MODE_SPARE, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF), 1'b1,
        plain(pps_pkg::STATUS_OK, 1'b0, 16'd1, 1'b1));
    add(mk(pps_pkg::MODE_CLEAR, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF), 1'b1,
        plain(pps_pkg::STATUS_OK, 1'b0, 16'd0, 1'b1));
    add(mk(pps_pkg::MODE_LOAD, 8'hFF, 16'hFFFF, 16'h0000, 8'hFF), 1'b1,
        plain(pps_pkg::STATUS_ZERO_BURST, 1'b0, 16'd0, 1'b1));
    // tie on priority between slots 1 and 2, one task that never arrives
    add(mk(pps_pkg::MODE_LOAD, 8'hFF, 16'd0, 16'd1, 8'hFF));
    add(mk(pps_pkg::MODE_LOAD, 8'h00, 16'd0, 16'd3, 8'h00));
    add(mk(pps_pkg::MODE_LOAD, 8'h05, 16'd2, 16'd2, 8'h00));
    add(mk(pps_pkg::MODE_LOAD, 8'h09, 16'hFFFF, 16'hFFFF, 8'h00));
    repeat (8) add(mk(pps_pkg::MODE_TICK, 0, 0, 0, 0));
    // a task after an idle gap starts a new segment
    add(mk(pps_pkg::MODE_LOAD, 8'hFF, 16'd0, 16'd1, 8'h07));
    add(mk(pps_pkg::MODE_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF));
    add(mk(MODE_SPARE, 0, 0, 0, 0));
    add(mk(pps_pkg::MODE_CLEAR, 0, 0, 0, 0), 1'b1,
        plain(pps_pkg::STATUS_OK, 1'b0, 16'd0, 1'b1));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (script[i]) send(script[i].r, script[i].typed, script[i].want);

    base = sent;
    set_no = 0;
    while (sent - base < RAND_ITEMS) begin
      gaps_on = ($urandom_range(0, 4) != 0);
      if (set_no == 4) begin
        // keep offering while the output side holds off
        gaps_on = 1'b0;
        want_hold = 1'b1;
      end
      if ($urandom_range(0, 99) < 85)
        send(mk(pps_pkg::MODE_CLEAR, 8'($urandom_range(0, 255)),
                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                8'($urandom_range(0, 255))));
      nl = $urandom_range(1, 20);
      repeat (nl) send(rand_load());
      nt = $urandom_range(4, 50);
      repeat (nt) begin
        if ($urandom_range(0, 14) == 0) send(rand_any());
        else send(mk(pps_pkg::MODE_TICK, 8'($urandom_range(0, 255)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     8'($urandom_range(0, 255))));
      end
      set_no++;
    end

    req_valid <= 1'b0;
    gaps_on = 1'b0;
    while (sched_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d transactions in %0d random task sets: %0d loads, %0d ticks,",
             sent, set_no, n_load, n_tick);
    $display("%0d clears, %0d spare, %0d task completions, %0d saturated ticks",
             n_clear, n_spare, n_fin, n_sat);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: preemptive_priority_scheduler.f
+incdir+src
src/pps_pkg.sv
src/pps_table.sv
src/pps_serial_sub.sv
src/preemptive_priority_scheduler.sv
src/pps_checker.sv
dv/preemptive_priority_scheduler_tb.sv
